/* sv/camr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// camr_pkg
// shared types and codes for the addressing mode resolver
// ----------------------------------------------------------------------------
package camr_pkg;

    // addressing mode codes (codes above AM_ZERO_PAGE_Y behave as implied)
    localparam logic [3:0] AM_ACCUM        = 4'd0;
    localparam logic [3:0] AM_ABSOLUTE     = 4'd1;
    localparam logic [3:0] AM_ABSOLUTE_X   = 4'd2;
    localparam logic [3:0] AM_ABSOLUTE_Y   = 4'd3;
    localparam logic [3:0] AM_IMMEDIATE    = 4'd4;
    localparam logic [3:0] AM_IMPLIED      = 4'd5;
    localparam logic [3:0] AM_INDIRECT     = 4'd6;
    localparam logic [3:0] AM_PRE_INDEXED  = 4'd7;
    localparam logic [3:0] AM_POST_INDEXED = 4'd8;
    localparam logic [3:0] AM_RELATIVE     = 4'd9;
    localparam logic [3:0] AM_ZERO_PAGE    = 4'd10;
    localparam logic [3:0] AM_ZERO_PAGE_X  = 4'd11;
    localparam logic [3:0] AM_ZERO_PAGE_Y  = 4'd12;

    // argument kind codes
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_ADDR = 2'd2;

    // extra cycles charged per mode group
    localparam logic [2:0] CYC_NONE = 3'd0;
    localparam logic [2:0] CYC_IMM  = 3'd1;
    localparam logic [2:0] CYC_ZP   = 3'd2;
    localparam logic [2:0] CYC_ABS  = 3'd3;
    localparam logic [2:0] CYC_ZPTR = 3'd5;
    localparam logic [2:0] CYC_IND  = 3'd7;

    // decoded controls for one transaction
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] nbytes;
        logic [2:0] cyc;
        logic       pused;
        logic       zp_wrap;   // effective address stays in page zero
        logic       ptr_carry; // second pointer byte may cross a page
        logic       cin;       // carry into the address adder
    } t_ctrl;

    // decode stage contents
    typedef struct packed {
        t_ctrl       ctrl;
        logic [15:0] op_a;
        logic [15:0] op_b;
        logic [15:0] pbase;
        logic [15:0] pc;
    } t_s1;

    // address stage contents
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  nbytes;
        logic [2:0]  cyc;
        logic        pused;
        logic [15:0] addr;
        logic [15:0] next_pc;
        logic [15:0] paddr;
        logic [15:0] pnext;
    } t_s2;

endpackage : camr_pkg
`default_nettype wire

/* sv/camr_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// camr_decode
// mode decode and selection of the address adder operands
// ----------------------------------------------------------------------------
module camr_decode
    import camr_pkg::*;
(
    input  wire logic [3:0]  i_opcode,
    input  wire logic [7:0]  i_operand_lo,
    input  wire logic [7:0]  i_operand_hi,
    input  wire logic [7:0]  i_pointer_lo,
    input  wire logic [7:0]  i_pointer_hi,
    input  wire logic [7:0]  i_index_x,
    input  wire logic [7:0]  i_index_y,
    input  wire logic [7:0]  i_accumulator,
    input  wire logic [15:0] i_pc_in,
    output t_s1              o_s1
);

    logic [15:0] w_opnd16;
    logic [15:0] w_ptr16;
    logic [7:0]  w_zpx_ptr;

    assign w_opnd16  = {i_operand_hi, i_operand_lo};
    assign w_ptr16   = {i_pointer_hi, i_pointer_lo};
    assign w_zpx_ptr = i_operand_lo + i_index_x;

    always_comb begin
        o_s1      = '0;
        o_s1.pc   = i_pc_in;
        unique case (i_opcode)
            AM_ACCUM: begin
                o_s1.ctrl.kind = KIND_BYTE;
                o_s1.op_a      = {8'h00, i_accumulator};
            end
            AM_ABSOLUTE, AM_ABSOLUTE_X, AM_ABSOLUTE_Y: begin
                o_s1.ctrl.kind   = KIND_ADDR;
                o_s1.ctrl.nbytes = 2'd2;
                o_s1.ctrl.cyc    = CYC_ABS;
                o_s1.op_a        = w_opnd16;
                if (i_opcode == AM_ABSOLUTE_X) begin
                    o_s1.op_b = {8'h00, i_index_x};
                end else if (i_opcode == AM_ABSOLUTE_Y) begin
                    o_s1.op_b = {8'h00, i_index_y};
                end
            end
            AM_IMMEDIATE: begin
                o_s1.ctrl.kind   = KIND_BYTE;
                o_s1.ctrl.nbytes = 2'd1;
                o_s1.ctrl.cyc    = CYC_IMM;
                o_s1.op_a        = {8'h00, i_operand_lo};
            end
            AM_INDIRECT: begin
                o_s1.ctrl.kind      = KIND_ADDR;
                o_s1.ctrl.nbytes    = 2'd2;
                o_s1.ctrl.cyc       = CYC_IND;
                o_s1.ctrl.pused     = 1'b1;
                o_s1.ctrl.ptr_carry = 1'b1;
                o_s1.op_a           = w_ptr16;
                o_s1.pbase          = w_opnd16;
            end
            AM_PRE_INDEXED: begin
                o_s1.ctrl.kind   = KIND_ADDR;
                o_s1.ctrl.nbytes = 2'd1;
                o_s1.ctrl.cyc    = CYC_ZPTR;
                o_s1.ctrl.pused  = 1'b1;
                o_s1.op_a        = w_ptr16;
                o_s1.pbase       = {8'h00, w_zpx_ptr};
            end
            AM_POST_INDEXED: begin
                o_s1.ctrl.kind   = KIND_ADDR;
                o_s1.ctrl.nbytes = 2'd1;
                o_s1.ctrl.cyc    = CYC_ZPTR;
                o_s1.ctrl.pused  = 1'b1;
                o_s1.op_a        = w_ptr16;
                o_s1.op_b        = {8'h00, i_index_y};
                o_s1.pbase       = {8'h00, i_operand_lo};
            end
            AM_RELATIVE: begin
                // target is pc + 1 + sign-extended offset
                o_s1.ctrl.kind   = KIND_ADDR;
                o_s1.ctrl.nbytes = 2'd1;
                o_s1.ctrl.cyc    = CYC_IMM;
                o_s1.ctrl.cin    = 1'b1;
                o_s1.op_a        = i_pc_in;
                o_s1.op_b        = {{8{i_operand_lo[7]}}, i_operand_lo};
            end
            AM_ZERO_PAGE, AM_ZERO_PAGE_X, AM_ZERO_PAGE_Y: begin
                o_s1.ctrl.kind    = KIND_ADDR;
                o_s1.ctrl.nbytes  = 2'd1;
                o_s1.ctrl.cyc     = CYC_ZP;
                o_s1.ctrl.zp_wrap = 1'b1;
                o_s1.op_a         = {8'h00, i_operand_lo};
                if (i_opcode == AM_ZERO_PAGE_X) begin
                    o_s1.op_b = {8'h00, i_index_x};
                end else if (i_opcode == AM_ZERO_PAGE_Y) begin
                    o_s1.op_b = {8'h00, i_index_y};
                end
            end
            default: begin
                // implied and undefined codes: no argument
                o_s1.ctrl.kind = KIND_NONE;
            end
        endcase
    end

endmodule : camr_decode
`default_nettype wire

/* sv/cpu_addressing_mode_resolver.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_addressing_mode_resolver
// resolves one 8-bit cpu addressing mode per transaction
// ----------------------------------------------------------------------------
// usage
//   input channel i_valid / o_ready carries the mode, operand bytes, pointer
//   bytes, x, y, a and the operand pc; output channel o_valid / i_ready
//   carries the resolved argument, operand length, next pc, pointer
//   addresses and extra cycle count
//   three register stages: decode, address add, output format; a
//   transaction accepted at the input is registered in the decode, address
//   and output stages in that order before it reaches the outputs
//   throughput is one transaction per cycle, since every stage can load at
//   every edge; only receiver back-pressure slows it
//   each stage holds its data while the next one is full, so a stalled
//   receiver fills the pipe; o_ready falls only when all three stages hold
//   a transaction and i_ready is low
//   reset empties all stages; the block keeps no other state and has no
//   configuration
// ----------------------------------------------------------------------------
module cpu_addressing_mode_resolver
    import camr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [3:0]  i_opcode,
    input  wire logic [7:0]  i_operand_lo,
    input  wire logic [7:0]  i_operand_hi,
    input  wire logic [7:0]  i_pointer_lo,
    input  wire logic [7:0]  i_pointer_hi,
    input  wire logic [7:0]  i_index_x,
    input  wire logic [7:0]  i_index_y,
    input  wire logic [7:0]  i_accumulator,
    input  wire logic [15:0] i_pc_in,
    // output channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_arg_lo,
    output logic [7:0]       o_arg_hi,
    output logic [1:0]       o_arg_kind,
    output logic [1:0]       o_operand_bytes,
    output logic [15:0]      o_next_pc,
    output logic [15:0]      o_pointer_addr,
    output logic [15:0]      o_pointer_next_addr,
    output logic             o_pointer_used,
    output logic [2:0]       o_cycles_added
);

    // stage valid bits
    logic r_v1, r_v2, r_v3;
    // per-stage load enables: a stage may load when empty or draining
    logic w_en1, w_en2, w_en3;

    t_s1 w_s1;
    t_s1 r_s1;
    t_s2 n_s2;
    t_s2 r_s2;

    // output register
    logic [7:0]  r_arg_lo,  n_arg_lo;
    logic [7:0]  r_arg_hi,  n_arg_hi;
    logic [1:0]  r_kind;
    logic [1:0]  r_nbytes;
    logic [15:0] r_next_pc;
    logic [15:0] r_paddr;
    logic [15:0] r_pnext;
    logic        r_pused;
    logic [2:0]  r_cyc;

    assign w_en3   = ~r_v3 | i_ready;
    assign w_en2   = ~r_v2 | w_en3;
    assign w_en1   = ~r_v1 | w_en2;
    assign o_ready = w_en1;

    // stage 1: mode decode and operand selection
    camr_decode u_decode (
        .i_opcode      (i_opcode),
        .i_operand_lo  (i_operand_lo),
        .i_operand_hi  (i_operand_hi),
        .i_pointer_lo  (i_pointer_lo),
        .i_pointer_hi  (i_pointer_hi),
        .i_index_x     (i_index_x),
        .i_index_y     (i_index_y),
        .i_accumulator (i_accumulator),
        .i_pc_in       (i_pc_in),
        .o_s1          (w_s1)
    );

    // stage 2: 16-bit address add, pointer increment, next pc
    always_comb begin
        n_s2.kind    = r_s1.ctrl.kind;
        n_s2.nbytes  = r_s1.ctrl.nbytes;
        n_s2.cyc     = r_s1.ctrl.cyc;
        n_s2.pused   = r_s1.ctrl.pused;
        n_s2.addr    = r_s1.op_a + r_s1.op_b + {15'd0, r_s1.ctrl.cin};
        // zero-page indexing wraps at 8 bits
        if (r_s1.ctrl.zp_wrap) begin
            n_s2.addr[15:8] = 8'h00;
        end
        n_s2.next_pc = r_s1.pc + {14'd0, r_s1.ctrl.nbytes};
        n_s2.paddr   = r_s1.pbase;
        // indirect jump carries across pages, zero-page pointers stay in page zero
        if (!r_s1.ctrl.pused) begin
            n_s2.pnext = 16'd0;
        end else if (r_s1.ctrl.ptr_carry) begin
            n_s2.pnext = r_s1.pbase + 16'd1;
        end else begin
            n_s2.pnext = {8'h00, r_s1.pbase[7:0] + 8'd1};
        end
    end

    // stage 3: clear unused argument bytes
    always_comb begin
        n_arg_lo = (r_s2.kind == KIND_NONE) ? 8'h00 : r_s2.addr[7:0];
        n_arg_hi = (r_s2.kind == KIND_ADDR) ? r_s2.addr[15:8] : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1 <= w_s1;
        end
        if (w_en2) begin
            r_s2 <= n_s2;
        end
        if (w_en3) begin
            r_arg_lo  <= n_arg_lo;
            r_arg_hi  <= n_arg_hi;
            r_kind    <= r_s2.kind;
            r_nbytes  <= r_s2.nbytes;
            r_next_pc <= r_s2.next_pc;
            r_paddr   <= r_s2.paddr;
            r_pnext   <= r_s2.pnext;
            r_pused   <= r_s2.pused;
            r_cyc     <= r_s2.cyc;
        end
    end

    assign o_valid             = r_v3;
    assign o_arg_lo            = r_arg_lo;
    assign o_arg_hi            = r_arg_hi;
    assign o_arg_kind          = r_kind;
    assign o_operand_bytes     = r_nbytes;
    assign o_next_pc           = r_next_pc;
    assign o_pointer_addr      = r_paddr;
    assign o_pointer_next_addr = r_pnext;
    assign o_pointer_used      = r_pused;
    assign o_cycles_added      = r_cyc;

    // a full pipe with a stalled receiver must refuse new transactions
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && !i_ready) |-> !o_ready)
        else $error("input accepted while pipeline full and stalled");

    // a stalled stage 2 transaction must not overwrite the waiting output
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_next_pc) && $stable(o_arg_lo)))
        else $error("waiting result changed under stall");

    // pointer modes always resolve to an address
    a_ptr_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pointer_used) |-> (o_arg_kind == KIND_ADDR))
        else $error("pointer mode without address result");

    // unused pointer addresses and an unused high argument byte read as zero
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_pointer_used || (o_pointer_addr == 16'd0 &&
                      o_pointer_next_addr == 16'd0)) &&
                     (o_arg_kind == KIND_ADDR || o_arg_hi == 8'h00)))
        else $error("unused result field not cleared");

endmodule : cpu_addressing_mode_resolver
`default_nettype wire

/* test/cpu_addressing_mode_resolver_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpu_addressing_mode_resolver_tb
// self-checking bench: a directed table of addressing mode corner cases,
// then randomised transactions with random gaps on both channels; results
// are checked field by field against typed rows or the in-bench predictor
// ----------------------------------------------------------------------------
module cpu_addressing_mode_resolver_tb
    import camr_pkg::*;
();

    // codes above AM_ZERO_PAGE_Y are undefined and behave as implied
    localparam logic [3:0] AM_UNDEF_A = AM_ZERO_PAGE_Y + 4'd1;
    localparam logic [3:0] AM_UNDEF_B = AM_ZERO_PAGE_Y + 4'd2;
    localparam logic [3:0] AM_UNDEF_C = AM_ZERO_PAGE_Y + 4'd3;

    localparam int N_RANDOM    = 1630;
    localparam int WDOG_LIMIT  = 1000; // cycles with no transaction on either side
    localparam int LONG_HOLD   = 40;   // receiver back-pressure stretch
    localparam int HOLD_AT     = 300;  // random index where the back-pressure burst starts
    localparam int HOLD_LEN    = 60;
    localparam int DRAIN_AT    = 800;  // sender waits for an empty pipe here
    localparam int CALM_AT     = 1000; // stretch with no idling on either side
    localparam int CALM_LEN    = 150;
    localparam int TAIL_CYCLES = 8;    // tail after the drain, longer than the 3-stage pipe

    // one input transaction
    typedef struct packed {
        logic [3:0]  opcode;
        logic [7:0]  olo;
        logic [7:0]  ohi;
        logic [7:0]  plo;
        logic [7:0]  phi;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  a;
        logic [15:0] pc;
    } t_item;

    // one resolved result
    typedef struct packed {
        logic [7:0]  arg_lo;
        logic [7:0]  arg_hi;
        logic [1:0]  kind;
        logic [1:0]  nbytes;
        logic [15:0] next_pc;
        logic [15:0] paddr;
        logic [15:0] pnext;
        logic        pused;
        logic [2:0]  cyc;
    } t_res;

    // directed table row: typed rows carry their own expected result
    typedef struct packed {
        t_item item;
        logic  typed;
        t_res  res;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_arg_lo;
    logic [7:0]  o_arg_hi;
    logic [1:0]  o_arg_kind;
    logic [1:0]  o_operand_bytes;
    logic [15:0] o_next_pc;
    logic [15:0] o_pointer_addr;
    logic [15:0] o_pointer_next_addr;
    logic        o_pointer_used;
    logic [2:0]  o_cycles_added;

    // payload on offer plus the typed expectation that travels with it
    t_item       offer_item;
    logic        offer_typed;
    t_res        offer_res;

    t_res        resolved_q [$];
    t_dir_row    dir_tab [$];
    int          err_cnt;
    int          idle_cycles;
    bit          hold_req;
    bit          calm;

    cpu_addressing_mode_resolver u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_opcode            (offer_item.opcode),
        .i_operand_lo        (offer_item.olo),
        .i_operand_hi        (offer_item.ohi),
        .i_pointer_lo        (offer_item.plo),
        .i_pointer_hi        (offer_item.phi),
        .i_index_x           (offer_item.x),
        .i_index_y           (offer_item.y),
        .i_accumulator       (offer_item.a),
        .i_pc_in             (offer_item.pc),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_arg_lo            (o_arg_lo),
        .o_arg_hi            (o_arg_hi),
        .o_arg_kind          (o_arg_kind),
        .o_operand_bytes     (o_operand_bytes),
        .o_next_pc           (o_next_pc),
        .o_pointer_addr      (o_pointer_addr),
        .o_pointer_next_addr (o_pointer_next_addr),
        .o_pointer_used      (o_pointer_used),
        .o_cycles_added      (o_cycles_added)
    );

    // ------------------------------------------------------------------
    // predictor: resolves one mode exactly as the block should
    // ------------------------------------------------------------------
    function automatic t_res resolve_mode(t_item it);
        logic [15:0] ea;
        logic [15:0] opnd;
        logic [15:0] ptr;
        logic [7:0]  zp;
        t_res        r;
        opnd = {it.ohi, it.olo};
        ptr  = {it.phi, it.plo};
        ea   = 16'h0000;
        r    = '0;
        case (it.opcode)
            AM_ACCUM: begin
                ea     = {8'h00, it.a};
                r.kind = KIND_BYTE;
            end
            AM_ABSOLUTE: begin
                ea       = opnd;
                r.kind   = KIND_ADDR;
                r.nbytes = 2'd2;
                r.cyc    = CYC_ABS;
            end
            AM_ABSOLUTE_X: begin
                // full 16-bit wrap
                ea       = opnd + {8'h00, it.x};
                r.kind   = KIND_ADDR;
                r.nbytes = 2'd2;
                r.cyc    = CYC_ABS;
            end
            AM_ABSOLUTE_Y: begin
                ea       = opnd + {8'h00, it.y};
                r.kind   = KIND_ADDR;
                r.nbytes = 2'd2;
                r.cyc    = CYC_ABS;
            end
            AM_IMMEDIATE: begin
                ea       = {8'h00, it.olo};
                r.kind   = KIND_BYTE;
                r.nbytes = 2'd1;
                r.cyc    = CYC_IMM;
            end
            AM_INDIRECT: begin
                // second pointer byte carries across the page
                r.paddr  = opnd;
                r.pnext  = opnd + 16'd1;
                r.pused  = 1'b1;
                ea       = ptr;
                r.kind   = KIND_ADDR;
                r.nbytes = 2'd2;
                r.cyc    = CYC_IND;
            end
            AM_PRE_INDEXED: begin
                // pointer and its second byte stay in page zero
                zp       = it.olo + it.x;
                r.paddr  = {8'h00, zp};
                r.pnext  = {8'h00, zp + 8'd1};
                r.pused  = 1'b1;
                ea       = ptr;
                r.kind   = KIND_ADDR;
                r.nbytes = 2'd1;
                r.cyc    = CYC_ZPTR;
            end
            AM_POST_INDEXED: begin
                zp       = it.olo;
                r.paddr  = {8'h00, zp};
                r.pnext  = {8'h00, zp + 8'd1};
                r.pused  = 1'b1;
                ea       = ptr + {8'h00, it.y};
                r.kind   = KIND_ADDR;
                r.nbytes = 2'd1;
                r.cyc    = CYC_ZPTR;
            end
            AM_RELATIVE: begin
                // signed offset from the byte after the offset
                ea       = it.pc + 16'd1 + {{8{it.olo[7]}}, it.olo};
                r.kind   = KIND_ADDR;
                r.nbytes = 2'd1;
                r.cyc    = CYC_IMM;
            end
            AM_ZERO_PAGE: begin
                ea       = {8'h00, it.olo};
                r.kind   = KIND_ADDR;
                r.nbytes = 2'd1;
                r.cyc    = CYC_ZP;
            end
            AM_ZERO_PAGE_X: begin
                zp       = it.olo + it.x;
                ea       = {8'h00, zp};
                r.kind   = KIND_ADDR;
                r.nbytes = 2'd1;
                r.cyc    = CYC_ZP;
            end
            AM_ZERO_PAGE_Y: begin
                zp       = it.olo + it.y;
                ea       = {8'h00, zp};
                r.kind   = KIND_ADDR;
                r.nbytes = 2'd1;
                r.cyc    = CYC_ZP;
            end
            default: begin
                // implied and undefined modes: nothing resolved
            end
        endcase
        r.arg_lo  = ea[7:0];
        r.arg_hi  = (r.kind == KIND_ADDR) ? ea[15:8] : 8'h00;
        r.next_pc = it.pc + {14'd0, r.nbytes};
        return r;
    endfunction

    function automatic t_item mk_item(logic [3:0] op, logic [7:0] olo, logic [7:0] ohi,
                                      logic [7:0] plo, logic [7:0] phi, logic [7:0] x,
                                      logic [7:0] y, logic [7:0] a, logic [15:0] pc);
        return {op, olo, ohi, plo, phi, x, y, a, pc};
    endfunction

    function automatic t_res mk_res(logic [7:0] lo, logic [7:0] hi, logic [1:0] kind,
                                    logic [1:0] nb, logic [15:0] npc, logic [15:0] pa,
                                    logic [15:0] pn, logic pu, logic [2:0] cyc);
        return {lo, hi, kind, nb, npc, pa, pn, pu, cyc};
    endfunction

    // byte biased towards the values that break carries and signs
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h80;
            3:       return 8'h7f;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_pc();
        case ($urandom_range(0, 15))
            0:       return 16'hffff;
            1:       return 16'h0000;
            2:       return 16'hfffe;
            3:       return 16'h00ff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_item pick_item();
        logic [3:0] op;
        // mostly defined modes, a few undefined ones as noise
        if ($urandom_range(0, 99) < 92)
            op = 4'($urandom_range(0, 12));
        else
            op = 4'($urandom_range(13, 15));
        return mk_item(op, pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                       pick_byte(), pick_byte(), pick_byte(), pick_pc());
    endfunction

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // offer one transaction and hold it until it is taken
    task automatic offer(t_item it, logic typed, t_res res, bit no_gap);
        int gap;
        gap = (no_gap || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        offer_item  <= it;
        offer_typed <= typed;
        offer_res   <= res;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // monitor: both handshakes sampled at the rising edge, input side
    // first so that ordering within the step never matters
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                resolved_q.push_back(offer_typed ? offer_res : resolve_mode(offer_item));
            if (o_valid && i_ready) begin
                if (resolved_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    err_cnt++;
                end else begin
                    exp_r = resolved_q.pop_front();
                    check_field("arg_lo", exp_r.arg_lo, o_arg_lo);
                    check_field("arg_hi", exp_r.arg_hi, o_arg_hi);
                    check_field("arg_kind", exp_r.kind, o_arg_kind);
                    check_field("operand_bytes", exp_r.nbytes, o_operand_bytes);
                    check_field("next_pc", exp_r.next_pc, o_next_pc);
                    check_field("pointer_addr", exp_r.paddr, o_pointer_addr);
                    check_field("pointer_next_addr", exp_r.pnext, o_pointer_next_addr);
                    check_field("pointer_used", exp_r.pused, o_pointer_used);
                    check_field("cycles_added", exp_r.cyc, o_cycles_added);
                end
            end
            // watchdog count: any transaction on either side clears it
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // watchdog
    initial begin
        wait (idle_cycles >= WDOG_LIMIT);
        $display("cpu_addressing_mode_resolver_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, one long hold-off on request, none while calm
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        i_ready    = 1'b0;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (hold_req) begin
                // long back-pressure so the pipe fills and o_ready drops
                hold_req   = 1'b0;
                i_ready    <= 1'b0;
                stall_left = LONG_HOLD - 1;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                i_ready    <= 1'b0;
                stall_left = pick_gap() - 1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender and run control
    // ------------------------------------------------------------------
    initial begin
        t_dir_row row;
        t_item    it;
        bit       burst;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        offer_item  = '0;
        offer_typed = 1'b0;
        offer_res   = '0;
        err_cnt     = 0;
        idle_cycles = 0;
        hold_req    = 1'b0;
        calm        = 1'b0;

        // directed corner cases
        // straight after reset: implied, everything zero
        dir_tab.push_back({mk_item(AM_IMPLIED, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 16'h0000), 1'b1,
                           mk_res(8'h00, 8'h00, KIND_NONE, 2'd0, 16'h0000, 16'h0000, 16'h0000,
                                  1'b0, CYC_NONE)});
        // accumulator, pointer bytes ignored
        dir_tab.push_back({mk_item(AM_ACCUM, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                                   16'h1234), 1'b1,
                           mk_res(8'hff, 8'h00, KIND_BYTE, 2'd0, 16'h1234, 16'h0000, 16'h0000,
                                  1'b0, CYC_NONE)});
        dir_tab.push_back({mk_item(AM_ACCUM, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                   16'hffff), 1'b0, t_res'(0)});
        // absolute, next pc wraps
        dir_tab.push_back({mk_item(AM_ABSOLUTE, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 16'hfffe), 1'b1,
                           mk_res(8'hff, 8'hff, KIND_ADDR, 2'd2, 16'h0000, 16'h0000, 16'h0000,
                                  1'b0, CYC_ABS)});
        // absolute indexing wraps at 16 bits
        dir_tab.push_back({mk_item(AM_ABSOLUTE_X, 8'hff, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00,
                                   8'h00, 16'hffff), 1'b1,
                           mk_res(8'hfe, 8'h00, KIND_ADDR, 2'd2, 16'h0001, 16'h0000, 16'h0000,
                                  1'b0, CYC_ABS)});
        dir_tab.push_back({mk_item(AM_ABSOLUTE_X, 8'hf0, 8'h12, 8'h00, 8'h00, 8'h20, 8'h55,
                                   8'h00, 16'h4000), 1'b0, t_res'(0)});
        dir_tab.push_back({mk_item(AM_ABSOLUTE_Y, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h01,
                                   8'h00, 16'h8000), 1'b1,
                           mk_res(8'h00, 8'h00, KIND_ADDR, 2'd2, 16'h8002, 16'h0000, 16'h0000,
                                  1'b0, CYC_ABS)});
        dir_tab.push_back({mk_item(AM_ABSOLUTE_Y, 8'h80, 8'h7f, 8'h00, 8'h00, 8'h33, 8'h80,
                                   8'h00, 16'h7fff), 1'b0, t_res'(0)});
        // immediate
        dir_tab.push_back({mk_item(AM_IMMEDIATE, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00,
                                   8'h00, 16'hffff), 1'b1,
                           mk_res(8'hff, 8'h00, KIND_BYTE, 2'd1, 16'h0000, 16'h0000, 16'h0000,
                                  1'b0, CYC_IMM)});
        dir_tab.push_back({mk_item(AM_IMMEDIATE, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'hff,
                                   8'hff, 16'h0100), 1'b0, t_res'(0)});
        // indirect jump, second pointer byte crosses the page
        dir_tab.push_back({mk_item(AM_INDIRECT, 8'hff, 8'h12, 8'h34, 8'h56, 8'h00, 8'h00,
                                   8'h00, 16'h0200), 1'b1,
                           mk_res(8'h34, 8'h56, KIND_ADDR, 2'd2, 16'h0202, 16'h12ff, 16'h1300,
                                  1'b1, CYC_IND)});
        // indirect jump, pointer wraps at 16 bits
        dir_tab.push_back({mk_item(AM_INDIRECT, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00,
                                   8'h00, 16'h0000), 1'b1,
                           mk_res(8'hff, 8'hff, KIND_ADDR, 2'd2, 16'h0002, 16'hffff, 16'h0000,
                                  1'b1, CYC_IND)});
        // (zp,x): second pointer byte wraps inside page zero
        dir_tab.push_back({mk_item(AM_PRE_INDEXED, 8'hfe, 8'h00, 8'h00, 8'h80, 8'h01, 8'h00,
                                   8'h00, 16'h0300), 1'b1,
                           mk_res(8'h00, 8'h80, KIND_ADDR, 2'd1, 16'h0301, 16'h00ff, 16'h0000,
                                  1'b1, CYC_ZPTR)});
        dir_tab.push_back({mk_item(AM_PRE_INDEXED, 8'hff, 8'hff, 8'hc3, 8'h3c, 8'h01, 8'h00,
                                   8'h00, 16'hffff), 1'b0, t_res'(0)});
        // (zp),y: page-zero wrap on the pointer, 16-bit wrap on the sum
        dir_tab.push_back({mk_item(AM_POST_INDEXED, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00, 8'hff,
                                   8'h00, 16'h1000), 1'b1,
                           mk_res(8'hfe, 8'h00, KIND_ADDR, 2'd1, 16'h1001, 16'h00ff, 16'h0000,
                                  1'b1, CYC_ZPTR)});
        dir_tab.push_back({mk_item(AM_POST_INDEXED, 8'h10, 8'h00, 8'hf0, 8'h20, 8'h00, 8'h10,
                                   8'h00, 16'h2000), 1'b0, t_res'(0)});
        // relative: most negative offset, and most positive offset past the top
        dir_tab.push_back({mk_item(AM_RELATIVE, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 16'h0000), 1'b1,
                           mk_res(8'h81, 8'hff, KIND_ADDR, 2'd1, 16'h0001, 16'h0000, 16'h0000,
                                  1'b0, CYC_IMM)});
        dir_tab.push_back({mk_item(AM_RELATIVE, 8'h7f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 16'hffff), 1'b1,
                           mk_res(8'h7f, 8'h00, KIND_ADDR, 2'd1, 16'h0000, 16'h0000, 16'h0000,
                                  1'b0, CYC_IMM)});
        dir_tab.push_back({mk_item(AM_RELATIVE, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 16'h1000), 1'b0, t_res'(0)});
        // zero page and its 8-bit indexing wrap
        dir_tab.push_back({mk_item(AM_ZERO_PAGE, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'h00, 16'h0040), 1'b0, t_res'(0)});
        dir_tab.push_back({mk_item(AM_ZERO_PAGE_X, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00,
                                   8'h00, 16'h0050), 1'b0, t_res'(0)});
        dir_tab.push_back({mk_item(AM_ZERO_PAGE_Y, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
                                   8'h00, 16'h0060), 1'b0, t_res'(0)});
        // undefined modes behave as implied
        dir_tab.push_back({mk_item(AM_UNDEF_A, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                                   8'hff, 16'hffff), 1'b1,
                           mk_res(8'h00, 8'h00, KIND_NONE, 2'd0, 16'hffff, 16'h0000, 16'h0000,
                                  1'b0, CYC_NONE)});
        dir_tab.push_back({mk_item(AM_UNDEF_B, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa,
                                   8'h55, 16'haaaa), 1'b0, t_res'(0)});
        dir_tab.push_back({mk_item(AM_UNDEF_C, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55,
                                   8'haa, 16'h5555), 1'b0, t_res'(0)});

        // synchronous reset, released on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[k]) begin
            row = dir_tab[k];
            offer(row.item, row.typed, row.res, 1'b0);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == DRAIN_AT) begin
                // sender pauses until the pipe is empty
                @(negedge i_clk);
                i_valid <= 1'b0;
                while (resolved_q.size() != 0) @(posedge i_clk);
            end
            if (n == HOLD_AT)
                hold_req = 1'b1;
            calm  = (n >= CALM_AT) && (n < CALM_AT + CALM_LEN);
            burst = calm || ((n >= HOLD_AT) && (n < HOLD_AT + HOLD_LEN));
            it    = pick_item();
            offer(it, 1'b0, t_res'(0), burst);
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        calm = 1'b0;

        // drain, then a few more cycles for anything stray
        while (resolved_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("cpu_addressing_mode_resolver_tb: clean");
        end else begin
            $display("cpu_addressing_mode_resolver_tb: errors");
        end
        $finish;
    end

endmodule
